FILE: sv/dcp_pkg.sv
`default_nettype none
package dcp_pkg;

    localparam int SQRT_STEPS = 33;

    typedef struct packed {
        logic [9:0]         idx1;
        logic [9:0]         idx2;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic               mv1;
        logic               mv2;
        logic [30:0]        rest;
        logic               degen;
        logic               neg_x;
        logic               neg_y;
        logic [32:0]        mag_x;
        logic [32:0]        mag_y;
    } t_link;

endpackage
`default_nettype wire

FILE: sv/dcp_sqrt.sv
`default_nettype none
module dcp_sqrt
    import dcp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_vld,
    input  wire  [65:0] i_rad,
    input  wire  t_link i_link,
    output logic        o_vld,
    output logic [32:0] o_root,
    output t_link       o_link
);

    logic        r_vld  [0:SQRT_STEPS-1];
    logic [35:0] r_rem  [0:SQRT_STEPS-1];
    logic [32:0] r_root [0:SQRT_STEPS-1];
    logic [65:0] r_rad  [0:SQRT_STEPS-1];
    t_link       r_link [0:SQRT_STEPS-1];

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic        p_vld;
        logic [35:0] p_rem;
        logic [32:0] p_root;
        logic [65:0] p_rad;
        t_link       p_link;
        logic [35:0] sh;
        logic [35:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_link = i_link;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_link = r_link[k-1];
        end

        assign sh    = {p_rem[33:0], p_rad[65:64]};
        assign trial = {1'b0, p_root, 2'b01};
        assign ge    = (sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (sh - trial) : sh;
                r_root[k] <= {p_root[31:0], ge};
                r_rad[k]  <= {p_rad[63:0], 2'b00};
                r_link[k] <= p_link;
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STEPS-1];
    assign o_root = r_root[SQRT_STEPS-1];
    assign o_link = r_link[SQRT_STEPS-1];

endmodule
`default_nettype wire

FILE: sv/dcp_div.sv
`default_nettype none
module dcp_div #(
    parameter int QW = 18
) (
    input  wire           i_clk,
    input  wire           i_en,
    input  wire  [34:0]   i_rem,
    input  wire  [QW-1:0] i_low,
    input  wire  [34:0]   i_den,
    output logic [QW-1:0] o_quo
);

    logic [34:0]   r_rem [0:QW-1];
    logic [QW-1:0] r_low [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];
    logic [34:0]   r_den [0:QW-1];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [34:0]   p_rem;
        logic [QW-1:0] p_low;
        logic [QW-1:0] p_quo;
        logic [34:0]   p_den;
        logic [35:0]   sh;
        logic [35:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign p_rem = i_rem;
            assign p_low = i_low;
            assign p_quo = '0;
            assign p_den = i_den;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_low = r_low[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
        end

        assign sh   = {p_rem, p_low[QW-1]};
        assign ge   = (sh >= {1'b0, p_den});
        assign diff = sh - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[34:0] : sh[34:0];
                r_low[k] <= {p_low[QW-2:0], 1'b0};
                r_quo[k] <= {p_quo[QW-2:0], ge};
                r_den[k] <= p_den;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule
`default_nettype wire

FILE: sv/distance_constraint_projection.sv
`default_nettype none
// Distance constraint for one Verlet link per transfer. Positions are signed
// Q15.16; the link length is the floor square root of the squared distance,
// the unit direction carries FRAC_BITS fraction bits, and each movable
// particle moves by half the length error along it, saturated to 32 bits.
// Coincident particles pass through unchanged with o_degenerate set.
// A new link is taken every cycle unless o_stall is set; the 33-stage square
// root (one root bit per stage) is followed by the FRAC_BITS + 2 stage
// divider (one quotient bit per stage). The whole pipeline holds while a
// finished result is stalled.
module distance_constraint_projection
    import dcp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [9:0]         i_first_index,
    input  wire  [9:0]         i_second_index,
    input  wire  signed [31:0] i_first_x,
    input  wire  signed [31:0] i_first_y,
    input  wire  signed [31:0] i_second_x,
    input  wire  signed [31:0] i_second_y,
    input  wire                i_first_movable,
    input  wire                i_second_movable,
    input  wire  [30:0]        i_anchor_length,
    output logic               o_valid,
    input  wire                i_stall,
    output logic [9:0]         o_out_first_index,
    output logic [9:0]         o_out_second_index,
    output logic signed [31:0] o_new_first_x,
    output logic signed [31:0] o_new_first_y,
    output logic signed [31:0] o_new_second_x,
    output logic signed [31:0] o_new_second_y,
    output logic               o_degenerate
);

    localparam int QW = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 35;
    localparam int PW = QW + 34;
    localparam int MW = PW - FRAC_BITS;

    function automatic logic [31:0] sat32(input logic [37:0] v);
        logic [31:0] r;
        begin
            r = v[31:0];
            if (!v[37] && (v[36:31] != 6'b000000)) r = 32'h7FFF_FFFF;
            if (v[37] && (v[36:31] != 6'b111111)) r = 32'h8000_0000;
            return r;
        end
    endfunction

    logic en;
    logic r_out_vld;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_vld;

    // stage A: differences
    logic [32:0] dx, dy;
    t_link       n_a_link, r_a_link;
    logic        r_a_vld;

    assign dx = {i_second_x[31], i_second_x} - {i_first_x[31], i_first_x};
    assign dy = {i_second_y[31], i_second_y} - {i_first_y[31], i_first_y};

    always_comb begin
        n_a_link.idx1  = i_first_index;
        n_a_link.idx2  = i_second_index;
        n_a_link.x1    = i_first_x;
        n_a_link.y1    = i_first_y;
        n_a_link.x2    = i_second_x;
        n_a_link.y2    = i_second_y;
        n_a_link.mv1   = i_first_movable;
        n_a_link.mv2   = i_second_movable;
        n_a_link.rest  = i_anchor_length;
        n_a_link.degen = (dx == '0) && (dy == '0);
        n_a_link.neg_x = dx[32];
        n_a_link.neg_y = dy[32];
        n_a_link.mag_x = dx[32] ? (33'd0 - dx) : dx;
        n_a_link.mag_y = dy[32] ? (33'd0 - dy) : dy;
    end

    // stage B: squares
    logic [65:0] r_b_sqx, r_b_sqy;
    t_link       r_b_link;
    logic        r_b_vld;

    // stage C: sum of squares
    logic [65:0] r_c_sum;
    t_link       r_c_link;
    logic        r_c_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_link <= n_a_link;
            r_b_sqx  <= {33'd0, r_a_link.mag_x} * {33'd0, r_a_link.mag_x};
            r_b_sqy  <= {33'd0, r_a_link.mag_y} * {33'd0, r_a_link.mag_y};
            r_b_link <= r_a_link;
            r_c_sum  <= r_b_sqx + r_b_sqy;
            r_c_link <= r_b_link;
        end
    end

    logic        sq_vld;
    logic [32:0] sq_root;
    t_link       sq_link;

    dcp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_rad   (r_c_sum),
        .i_link  (r_c_link),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_link  (sq_link)
    );

    // stage D: divider operands and length error
    logic [NW-1:0] num_x, num_y;
    logic [34:0]   err;
    logic [34:0]   err_neg;
    logic [34:0]   r_d_den, r_d_remx, r_d_remy;
    logic [QW-1:0] r_d_lowx, r_d_lowy;
    logic [33:0]   r_d_emag;
    logic          r_d_eneg;
    t_link         r_d_link;
    logic          r_d_vld;

    // numerator is 2*|d|*2^F + len, so the quotient rounds half away from zero
    assign num_x = ({{(FRAC_BITS+2){1'b0}}, sq_link.mag_x} << (FRAC_BITS + 1))
                 + {{(FRAC_BITS+2){1'b0}}, sq_root};
    assign num_y = ({{(FRAC_BITS+2){1'b0}}, sq_link.mag_y} << (FRAC_BITS + 1))
                 + {{(FRAC_BITS+2){1'b0}}, sq_root};
    assign err     = {4'b0000, sq_link.rest} - {2'b00, sq_root};
    assign err_neg = 35'd0 - err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_den  <= {1'b0, sq_root, 1'b0};
            r_d_remx <= {2'b00, num_x[NW-1:QW]};
            r_d_remy <= {2'b00, num_y[NW-1:QW]};
            r_d_lowx <= num_x[QW-1:0];
            r_d_lowy <= num_y[QW-1:0];
            r_d_eneg <= err[34];
            r_d_emag <= err[34] ? err_neg[33:0] : err[33:0];
            r_d_link <= sq_link;
        end
    end

    logic [QW-1:0] quo_x, quo_y;

    dcp_div #(.QW(QW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (r_d_remx),
        .i_low (r_d_lowx),
        .i_den (r_d_den),
        .o_quo (quo_x)
    );

    dcp_div #(.QW(QW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem (r_d_remy),
        .i_low (r_d_lowy),
        .i_den (r_d_den),
        .o_quo (quo_y)
    );

    // carry link data alongside the dividers
    logic [QW-1:0] r_q_vld;
    t_link         r_q_link [0:QW-1];
    logic [33:0]   r_q_emag [0:QW-1];
    logic          r_q_eneg [0:QW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= '0;
        end else if (en) begin
            r_q_vld <= {r_q_vld[QW-2:0], r_d_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_link[0] <= r_d_link;
            r_q_emag[0] <= r_d_emag;
            r_q_eneg[0] <= r_d_eneg;
            for (int k = 1; k < QW; k++) begin
                r_q_link[k] <= r_q_link[k-1];
                r_q_emag[k] <= r_q_emag[k-1];
                r_q_eneg[k] <= r_q_eneg[k-1];
            end
        end
    end

    // stage E: move magnitudes
    logic [PW-1:0] r_e_px, r_e_py;
    logic          r_e_negx, r_e_negy;
    t_link         r_e_link;
    logic          r_e_vld;

    // stage F: rounded, signed moves
    logic [PW:0]   rnd_x, rnd_y;
    logic [MW-1:0] mag_mx, mag_my;
    logic [MW:0]   r_f_mx, r_f_my;
    t_link         r_f_link;
    logic          r_f_vld;

    assign rnd_x  = {1'b0, r_e_px} + {{(PW-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    assign rnd_y  = {1'b0, r_e_py} + {{(PW-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    assign mag_mx = rnd_x[PW:FRAC_BITS+1];
    assign mag_my = rnd_y[PW:FRAC_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_q_vld[QW-1];
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_px   <= {34'd0, quo_x} * {{QW{1'b0}}, r_q_emag[QW-1]};
            r_e_py   <= {34'd0, quo_y} * {{QW{1'b0}}, r_q_emag[QW-1]};
            r_e_negx <= r_q_link[QW-1].neg_x ^ r_q_eneg[QW-1];
            r_e_negy <= r_q_link[QW-1].neg_y ^ r_q_eneg[QW-1];
            r_e_link <= r_q_link[QW-1];
            r_f_mx   <= r_e_negx ? ((MW+1)'(0) - {1'b0, mag_mx}) : {1'b0, mag_mx};
            r_f_my   <= r_e_negy ? ((MW+1)'(0) - {1'b0, mag_my}) : {1'b0, mag_my};
            r_f_link <= r_e_link;
        end
    end

    // stage G: apply moves and saturate
    logic [37:0] ext_x1, ext_y1, ext_x2, ext_y2, ext_mx, ext_my;
    logic [31:0] n_x1, n_y1, n_x2, n_y2;
    logic        hold1, hold2;

    assign ext_x1 = {{6{r_f_link.x1[31]}}, r_f_link.x1};
    assign ext_y1 = {{6{r_f_link.y1[31]}}, r_f_link.y1};
    assign ext_x2 = {{6{r_f_link.x2[31]}}, r_f_link.x2};
    assign ext_y2 = {{6{r_f_link.y2[31]}}, r_f_link.y2};
    assign ext_mx = {{(37-MW){r_f_mx[MW]}}, r_f_mx};
    assign ext_my = {{(37-MW){r_f_my[MW]}}, r_f_my};
    assign hold1  = r_f_link.degen || !r_f_link.mv1;
    assign hold2  = r_f_link.degen || !r_f_link.mv2;

    assign n_x1 = hold1 ? r_f_link.x1 : sat32(ext_x1 - ext_mx);
    assign n_y1 = hold1 ? r_f_link.y1 : sat32(ext_y1 - ext_my);
    assign n_x2 = hold2 ? r_f_link.x2 : sat32(ext_x2 + ext_mx);
    assign n_y2 = hold2 ? r_f_link.y2 : sat32(ext_y2 + ext_my);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_first_index  <= r_f_link.idx1;
            o_out_second_index <= r_f_link.idx2;
            o_new_first_x      <= n_x1;
            o_new_first_y      <= n_y1;
            o_new_second_x     <= n_x2;
            o_new_second_y     <= n_y2;
            o_degenerate       <= r_f_link.degen;
        end
    end

endmodule
`default_nettype wire
